>>> hw/rtl/tomlovt_pkg.sv
// Shared types and constants for the TOML open-value tracker.
// No dependencies; imported by tomlovt_scan and the top level.
package tomlovt_pkg;

  localparam int DEPTH_BITS_DEF = 8;   // default nesting counter width
  localparam int REPORT_W       = 8;   // width of reported depths

  // character codes
  localparam logic [7:0] CH_NL   = 8'd10;
  localparam logic [7:0] CH_DQ   = 8'd34;
  localparam logic [7:0] CH_HASH = 8'd35;
  localparam logic [7:0] CH_SQ   = 8'd39;
  localparam logic [7:0] CH_LBRK = 8'd91;
  localparam logic [7:0] CH_BSL  = 8'd92;
  localparam logic [7:0] CH_RBRK = 8'd93;
  localparam logic [7:0] CH_LBRC = 8'd123;
  localparam logic [7:0] CH_RBRC = 8'd125;

  // item opcodes
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    M_NORMAL   = 4'd0,
    M_DQ1      = 4'd1,
    M_DQ2      = 4'd2,
    M_SQ1      = 4'd3,
    M_SQ2      = 4'd4,
    M_DSTR     = 4'd5,
    M_DSTR_ESC = 4'd6,
    M_SSTR     = 4'd7,
    M_COMMENT  = 4'd8,
    M_DBLOCK   = 4'd9,
    M_SBLOCK   = 4'd10
  } mode_t;

  // one input item as held in the input register
  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } item_t;

  // one line-status result
  typedef struct packed {
    logic                value_open;
    logic                in_basic_block;
    logic                in_literal_block;
    logic [REPORT_W-1:0] bracket_depth;
    logic [REPORT_W-1:0] brace_depth;
  } res_t;

endpackage

>>> hw/rtl/tomlovt_scan.sv
// Scanner state registers and per-byte next-state logic.
// Depends on tomlovt_pkg.
module tomlovt_scan import tomlovt_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,         // commit the item this cycle
  input  item_t item,
  output logic  needs_out,  // item produces a result
  output res_t  res
);

  mode_t                 mode_r, mode_nxt;
  logic [1:0]            run_r, run_nxt;
  logic [DEPTH_BITS-1:0] brk_r, brk_nxt;
  logic [DEPTH_BITS-1:0] brc_r, brc_nxt;
  logic                  plain;
  logic                  is_nl;
  logic [7:0]            ch;

  assign ch        = item.char_code;
  assign is_nl     = (ch == CH_NL);
  assign needs_out = (item.op == OP_CHAR) && is_nl;

  always_comb begin
    mode_nxt = mode_r;
    run_nxt  = run_r;
    brk_nxt  = brk_r;
    brc_nxt  = brc_r;
    plain    = 1'b0;
    if (item.op == OP_CLEAR) begin
      mode_nxt = M_NORMAL;
      run_nxt  = 2'd0;
      brk_nxt  = '0;
      brc_nxt  = '0;
    end else if (is_nl) begin
      if (mode_r != M_DBLOCK && mode_r != M_SBLOCK) mode_nxt = M_NORMAL;
      run_nxt = 2'd0;
    end else begin
      unique case (mode_r)
        M_DQ1: begin
          if (ch == CH_DQ) mode_nxt = M_DQ2;
          else if (ch == CH_BSL) mode_nxt = M_DSTR_ESC;
          else mode_nxt = M_DSTR;
        end
        M_DQ2: begin
          if (ch == CH_DQ) begin
            mode_nxt = M_DBLOCK;
            run_nxt  = 2'd0;
          end else begin
            mode_nxt = M_NORMAL;
            plain    = 1'b1;
          end
        end
        M_SQ1: mode_nxt = (ch == CH_SQ) ? M_SQ2 : M_SSTR;
        M_SQ2: begin
          if (ch == CH_SQ) begin
            mode_nxt = M_SBLOCK;
            run_nxt  = 2'd0;
          end else begin
            mode_nxt = M_NORMAL;
            plain    = 1'b1;
          end
        end
        M_DSTR: begin
          if (ch == CH_DQ) mode_nxt = M_NORMAL;
          else if (ch == CH_BSL) mode_nxt = M_DSTR_ESC;
        end
        M_DSTR_ESC: mode_nxt = M_DSTR;
        M_SSTR:     if (ch == CH_SQ) mode_nxt = M_NORMAL;
        M_COMMENT:  mode_nxt = M_COMMENT;
        M_DBLOCK, M_SBLOCK: begin
          if (ch == ((mode_r == M_DBLOCK) ? CH_DQ : CH_SQ)) begin
            if (run_r == 2'd2) begin
              run_nxt  = 2'd0;
              mode_nxt = M_NORMAL;
            end else begin
              run_nxt = run_r + 2'd1;
            end
          end else begin
            run_nxt = 2'd0;
          end
        end
        default: begin   // normal and unused codes
          mode_nxt = M_NORMAL;
          plain    = 1'b1;
        end
      endcase

      // plain text outside strings
      if (plain) begin
        if (ch == CH_DQ) mode_nxt = M_DQ1;
        else if (ch == CH_SQ) mode_nxt = M_SQ1;
        else if (ch == CH_HASH) mode_nxt = M_COMMENT;
        else if (ch == CH_LBRK) begin
          if (brk_r != '1) brk_nxt = brk_r + 1'b1;
        end else if (ch == CH_RBRK) begin
          if (brk_r != '0) brk_nxt = brk_r - 1'b1;
        end else if (ch == CH_LBRC) begin
          if (brc_r != '1) brc_nxt = brc_r + 1'b1;
        end else if (ch == CH_RBRC) begin
          if (brc_r != '0) brc_nxt = brc_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      run_r  <= 2'd0;
      brk_r  <= '0;
      brc_r  <= '0;
    end else if (en) begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
      brk_r  <= brk_nxt;
      brc_r  <= brc_nxt;
    end
  end

  // line status; a newline leaves depths alone and only drops non-block modes
  always_comb begin
    res.in_basic_block   = (mode_r == M_DBLOCK);
    res.in_literal_block = (mode_r == M_SBLOCK);
    res.value_open       = res.in_basic_block || res.in_literal_block ||
                           (brk_r != '0) || (brc_r != '0);
    res.bracket_depth    = (brk_r > DEPTH_BITS'(255)) ? 8'hFF : REPORT_W'(brk_r);
    res.brace_depth      = (brc_r > DEPTH_BITS'(255)) ? 8'hFF : REPORT_W'(brc_r);
  end

  // closing-quote run only counts inside a block
  a_run_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r != 2'd0) |-> (mode_r == M_DBLOCK || mode_r == M_SBLOCK))
    else $error("quote run outside block");

  // clear restores reset state
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.op == OP_CLEAR) |=>
      (mode_r == M_NORMAL && run_r == 2'd0 && brk_r == '0 && brc_r == '0))
    else $error("clear did not reset state");

  // end of line leaves only block modes open
  a_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (en && needs_out) |=> (run_r == 2'd0 &&
      (mode_r == M_NORMAL || mode_r == M_DBLOCK || mode_r == M_SBLOCK)))
    else $error("newline left string or comment open");

  // bracket nesting changes by at most one per byte
  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.op == OP_CHAR) |=>
      (brk_r == $past(brk_r) || brk_r == $past(brk_r) + 1'b1 ||
       brk_r == $past(brk_r) - 1'b1))
    else $error("bracket depth jumped");

endmodule

>>> hw/rtl/toml_open_value_tracker_unit.sv
// Top level of the TOML open-value tracker: stream ports, input and result registers.
// Depends on tomlovt_pkg and tomlovt_scan.
//
// Path: a request is held in the input register; when the scanner commits it,
// the scanner update also loads the result register for a newline.
// Throughput: one byte per cycle; only a stalled result that a newline must
// replace holds input.
// Reset: synchronous active-low rst_n clears scan state and both valid flags.
module toml_open_value_tracker_unit import tomlovt_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF   // nesting counter width, 2..32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  input  logic        in_tuser,    // [0] op (0 = byte, 1 = clear)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // [0] value_open, [1] in_basic_block,
                                   // [2] in_literal_block, [10:3] bracket_depth,
                                   // [18:11] brace_depth, [23:19] zero
);

  item_t item_r;
  logic  in_valid_r;
  res_t  res_r;
  logic  out_valid_r;

  logic  needs_out;
  res_t  res;
  logic  out_free;
  logic  consume;

  // Output slot can take a new result if empty or being drained now.
  assign out_free  = !out_valid_r || out_tready;
  // Held request retires when it produces nothing or the slot is free.
  assign consume   = in_valid_r && (!needs_out || out_free);
  assign in_tready = !in_valid_r || consume;

  // Input register: payload without reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op        <= in_tuser;
      item_r.char_code <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  tomlovt_scan #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (consume),
    .item     (item_r),
    .needs_out(needs_out),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (consume && needs_out) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume && needs_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.brace_depth, res_r.bracket_depth,
                       res_r.in_literal_block, res_r.in_basic_block, res_r.value_open};

endmodule
